/* rtl/gspe_pkg.sv */
package gspe_pkg;

  localparam int MaxNodes   = 16;
  localparam int WeightBits = 16;
  localparam int NodeBits   = $clog2(MaxNodes);
  localparam int DistBits   = WeightBits + NodeBits + 1;
  localparam int EdgeDepth  = MaxNodes * MaxNodes;
  localparam int EdgeAddrW  = 2 * NodeBits;

  localparam logic [1:0] ActAdd   = 2'd0;
  localparam logic [1:0] ActDel   = 2'd1;
  localparam logic [1:0] ActQuery = 2'd2;
  localparam logic [1:0] ActNone  = 2'd3;

  localparam logic [1:0] StHop    = 2'd0;
  localparam logic [1:0] StNoPath = 2'd1;
  localparam logic [1:0] StSame   = 2'd2;

  typedef struct packed {
    logic [1:0]  action;
    logic [3:0]  node_a;
    logic [3:0]  node_b;
    logic [15:0] weight;
  } cmd_t;

  typedef struct packed {
    logic [3:0] hop_node;
    logic [1:0] status;
    logic       last;
  } res_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                load;     // capture the command and clear per-node state
    logic                wr_edge;  // write one direction of the edge
    logic                wr_swap;  // write direction b to a
    logic                wr_val;
    logic                scan_rd;  // read edge (best, idx) and node idx
    logic                min_step; // compare node idx for minimum
    logic                settle;   // settle the current best
    logic                relax;    // relax node at delayed index
    logic [NodeBits-1:0] idx;
    logic                walk_ld;  // start walk at destination
    logic                walk_step;
  } ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic                found;
    logic                dest_has_pred;
    logic [NodeBits-1:0] walk_pred;
    logic                walk_pred_ok;
    logic                walk_at_src;
  } sts_t;

endpackage

/* rtl/graph_shortest_path_engine_unit.sv */
// Channel  | Signals                      | Handshake
// command  | start_i, cmd_i, busy_o       | taken when start_i and !busy_o
// result   | res_valid_o, res_o           | one-cycle strobe, no backpressure
// config   | cfg_we_i, cfg_data_i         | written when cfg_we_i is high
// An edge transaction holds busy_o in S_EDGE1 and S_EDGE2, one write per
// matrix direction. A query runs in rounds: each round scans n nodes for
// the minimum, then reads n edge entries of the settled node through one port.
// The path walk follows predecessors from the destination. Reset clears the
// edge valid flags at once; no clearing pass. The receiver cannot stall results.
module graph_shortest_path_engine_unit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  gspe_pkg::cmd_t cmd_i,
  output logic           busy_o,
  input  logic           cfg_we_i,
  input  logic [4:0]     cfg_data_i,
  output logic           res_valid_o,
  output gspe_pkg::res_t res_o
);
  import gspe_pkg::*;

  logic [4:0] ncfg_q, n_eff;
  ctl_t ctl;
  sts_t sts;

  // Node count register, clamped to the supported range.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ncfg_q <= 5'(MaxNodes);
    else if (cfg_we_i) ncfg_q <= cfg_data_i;
  end
  assign n_eff = (ncfg_q == 5'd0) ? 5'd1 : ((ncfg_q > 5'(MaxNodes)) ? 5'(MaxNodes) : ncfg_q);

  gspe_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i, .cmd_i, .n_i(n_eff), .sts_i(sts),
    .ctl_o(ctl), .busy_o, .res_valid_o, .res_o
  );

  gspe_datapath u_dp (
    .clk_i, .rst_ni, .ctl_i(ctl), .cmd_i, .sts_o(sts)
  );

endmodule

/* rtl/gspe_datapath.sv */
module gspe_datapath (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  gspe_pkg::ctl_t ctl_i,
  input  gspe_pkg::cmd_t cmd_i,
  output gspe_pkg::sts_t sts_o
);
  import gspe_pkg::*;

  // Edge memory: valid flag and weight. Valid flags reset to cleared.
  logic [WeightBits-1:0] wmem [EdgeDepth];
  logic [EdgeDepth-1:0]  evalid_q;
  logic [WeightBits-1:0] rd_w_q;
  logic                  rd_v_q;

  logic [NodeBits-1:0] a_q, b_q, best_q, cur_q, id_q, rel_idx_q;
  logic [WeightBits-1:0] w_q;
  logic                found_q;
  logic [DistBits-1:0] dist_q [MaxNodes];
  logic [MaxNodes-1:0] fin_q, set_q, hasp_q;
  logic [NodeBits-1:0] pred_q [MaxNodes];
  logic [DistBits-1:0] bestd_q;

  logic [EdgeAddrW-1:0] waddr, raddr;
  assign waddr = ctl_i.wr_swap ? {b_q, a_q} : {a_q, b_q};
  assign raddr = {best_q, ctl_i.idx};

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_edge && ctl_i.wr_val) wmem[waddr] <= w_q;
    rd_w_q <= wmem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      evalid_q <= '0;
      rd_v_q   <= 1'b0;
    end else begin
      if (ctl_i.wr_edge) evalid_q[waddr] <= ctl_i.wr_val;
      rd_v_q <= evalid_q[raddr];
    end
  end

  // Search state: minimum scan, settling, relaxation and predecessor walk.
  logic [DistBits-1:0] cand;
  assign cand = bestd_q + DistBits'(rd_w_q);

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      a_q <= cmd_i.node_a;
      b_q <= cmd_i.node_b;
      w_q <= cmd_i.weight[WeightBits-1:0];
      for (int i = 0; i < MaxNodes; i++) dist_q[i] <= '0;
      fin_q   <= MaxNodes'(1) << cmd_i.node_a;
      set_q   <= '0;
      hasp_q  <= '0;
      found_q <= 1'b0;
    end
    if (ctl_i.scan_rd) rel_idx_q <= ctl_i.idx;
    if (ctl_i.min_step && !set_q[ctl_i.idx] && fin_q[ctl_i.idx] &&
        (!found_q || dist_q[ctl_i.idx] < dist_q[cur_q])) begin
      cur_q   <= ctl_i.idx;
      found_q <= 1'b1;
    end
    if (ctl_i.settle) begin
      set_q[cur_q] <= 1'b1;
      best_q       <= cur_q;
      bestd_q      <= dist_q[cur_q];
      found_q      <= 1'b0;
    end
    if (ctl_i.relax && rd_v_q && !set_q[rel_idx_q] &&
        (!fin_q[rel_idx_q] || cand < dist_q[rel_idx_q])) begin
      dist_q[rel_idx_q] <= cand;
      fin_q[rel_idx_q]  <= 1'b1;
      pred_q[rel_idx_q] <= best_q;
      hasp_q[rel_idx_q] <= 1'b1;
    end
    if (ctl_i.walk_ld) id_q <= b_q;
    else if (ctl_i.walk_step) id_q <= pred_q[id_q];
  end

  assign sts_o.found         = found_q;
  assign sts_o.dest_has_pred = hasp_q[b_q];
  assign sts_o.walk_pred     = pred_q[id_q];
  assign sts_o.walk_pred_ok  = hasp_q[id_q];
  assign sts_o.walk_at_src   = (pred_q[id_q] == a_q);

endmodule

/* rtl/gspe_ctrl.sv */
module gspe_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  gspe_pkg::cmd_t cmd_i,
  input  logic [4:0]     n_i,
  input  gspe_pkg::sts_t sts_i,
  output gspe_pkg::ctl_t ctl_o,
  output logic           busy_o,
  output logic           res_valid_o,
  output gspe_pkg::res_t res_o
);
  import gspe_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_EDGE1, S_EDGE2, S_MIN, S_SETTLE, S_RELAX, S_WALK
  } state_e;

  state_e state_q;
  logic [NodeBits:0] cnt_q;
  logic [1:0] act_q;
  logic [NodeBits:0] steps_q;
  logic [NodeBits:0] nm1;
  assign nm1 = n_i - 5'd1;

  logic accept;
  assign accept = start_i && (state_q == S_IDLE);

  // Combinational commands derived from state, counter, action and status.
  always_comb begin
    ctl_o = '0;
    ctl_o.idx       = cnt_q[NodeBits-1:0];
    ctl_o.load      = accept;
    ctl_o.wr_edge   = (state_q == S_EDGE1) || (state_q == S_EDGE2);
    ctl_o.wr_swap   = (state_q == S_EDGE2);
    ctl_o.wr_val    = (act_q == ActAdd);
    ctl_o.min_step  = (state_q == S_MIN) && (cnt_q <= nm1);
    ctl_o.settle    = (state_q == S_SETTLE) && sts_i.found;
    ctl_o.scan_rd   = (state_q == S_RELAX) && (cnt_q <= nm1);
    ctl_o.relax     = (state_q == S_RELAX) && (cnt_q != 0);
    ctl_o.walk_ld   = (state_q == S_SETTLE);
    ctl_o.walk_step = (state_q == S_WALK);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      act_q       <= ActAdd;
      steps_q     <= '0;
      res_valid_o <= 1'b0;
      res_o       <= '0;
    end else begin
      res_valid_o <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (start_i) begin
            act_q <= cmd_i.action;
            priority if (cmd_i.action == ActAdd || cmd_i.action == ActDel) begin
              state_q <= S_EDGE1;
            end else if (cmd_i.action == ActQuery) begin
              priority if ({1'b0, cmd_i.node_a} >= n_i || {1'b0, cmd_i.node_b} >= n_i) begin
                res_valid_o <= 1'b1;
                res_o <= '{hop_node: '0, status: StNoPath, last: 1'b1};
              end else if (cmd_i.node_a == cmd_i.node_b) begin
                res_valid_o <= 1'b1;
                res_o <= '{hop_node: cmd_i.node_a, status: StSame, last: 1'b1};
              end else begin
                state_q <= S_MIN;
                cnt_q   <= '0;
              end
            end
          end
        end
        S_EDGE1: state_q <= S_EDGE2;
        S_EDGE2: state_q <= S_IDLE;
        S_MIN: begin
          if (cnt_q == nm1) state_q <= S_SETTLE;
          else cnt_q <= cnt_q + 1'b1;
        end
        S_SETTLE: begin
          cnt_q <= '0;
          if (sts_i.found) state_q <= S_RELAX;
          else if (!sts_i.dest_has_pred) begin
            res_valid_o <= 1'b1;
            res_o <= '{hop_node: '0, status: StNoPath, last: 1'b1};
            state_q <= S_IDLE;
          end else begin
            state_q <= S_WALK;
            steps_q <= '0;
          end
        end
        S_RELAX: begin
          if (cnt_q == nm1 + 1'b1) begin
            state_q <= S_MIN;
            cnt_q   <= '0;
          end else cnt_q <= cnt_q + 1'b1;
        end
        S_WALK: begin
          if (sts_i.walk_pred_ok) begin
            res_valid_o <= 1'b1;
            res_o <= '{hop_node: sts_i.walk_pred, status: StHop, last: sts_i.walk_at_src};
          end
          steps_q <= steps_q + 1'b1;
          if (!sts_i.walk_pred_ok || sts_i.walk_at_src || steps_q + 1'b1 >= n_i[NodeBits:0])
            state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy_o = (state_q != S_IDLE);

  a_walk_has_pred: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SETTLE && !sts_i.found && sts_i.dest_has_pred) |=> state_q == S_WALK)
    else $error("walk not entered");
  a_res_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.status != StHop) |-> state_q == S_IDLE || state_q == S_MIN)
    else $error("terminal result while busy");
  a_edge_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EDGE2 |=> state_q == S_IDLE)
    else $error("edge write longer than one cycle");

endmodule
